@@ rtl/core/wcc_pkg.sv @@
package wcc_pkg;

    localparam int MAX_WORD_LEN = 8;
    localparam int WINDOW_DEPTH = MAX_WORD_LEN + 1;
    localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int SEL_W        = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int PAT_W        = 8 * MAX_WORD_LEN;
    localparam int COUNT_W      = 16;
    localparam int SEEN_W       = 4;

    localparam logic [7:0]         WORD_LIMIT = 8'h40;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [SEEN_W-1:0]  SEEN_MAX   = {SEEN_W{1'b1}};

    // configuration register indexes
    localparam logic REG_PATTERN_BYTES  = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    // compare results of one window cell
    typedef struct packed {
        logic eq_now;    // stored byte equals its pattern byte
        logic eq_next;   // incoming byte equals its pattern byte
        logic low_now;   // stored byte is a word separator
        logic low_next;  // incoming byte is a word separator
    } cell_flags_t;

    // pattern byte that window cell 'slot' faces for a word of length len
    function automatic logic [7:0] pat_for_cell(input logic [PAT_W-1:0] pat,
                                                input logic [3:0] len,
                                                input logic [3:0] slot);
        logic [3:0]       diff;
        logic [SEL_W-1:0] sel;
        diff = len - 4'd1 - slot;
        sel  = diff[SEL_W-1:0];
        return pat[8*sel +: 8];
    endfunction

endpackage

@@ rtl/core/wcc_cell.sv @@
module wcc_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  logic                 clear,
    input  logic [7:0]           pat_byte,
    input  logic [7:0]           byte_in,
    output logic [7:0]           byte_out,
    output wcc_pkg::cell_flags_t flags
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (clear) begin
            byte_next = 8'd0;
        end else if (shift_en) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'd0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out       = byte_reg;
    assign flags.eq_now   = (byte_reg == pat_byte);
    assign flags.eq_next  = (byte_in == pat_byte);
    assign flags.low_now  = (byte_reg < wcc_pkg::WORD_LIMIT);
    assign flags.low_next = (byte_in < wcc_pkg::WORD_LIMIT);

endmodule

@@ rtl/core/whole_word_occurrence_counter.sv @@
// Counts whole-word occurrences of a configured word (1 to 8 bytes) in a byte
// stream. Each s_ transfer carries one text byte; s_tlast marks the final byte
// of a text. A match counts only when the byte before it is below 0x40 or the
// word opens the text, and the byte after it is below 0x40 or the word closes
// the text. On the transfer with s_tlast set, one m_ transfer delivers the
// count (saturating at 65535) and the block starts over for the next text.
// Throughput is one byte per clock: a row of nine window cells shifts every
// accepted byte and all cells compare against the pattern in the same cycle,
// so the only stall comes from a count still waiting in the output register.
// The count is registered: it appears in the cycle after the last byte. Write
// pattern_bytes (index 0, first byte in the low bits) and pattern_length (index
// 1) on the cfg_ port only while no text is in flight; a length of 0 acts as 1
// and a length above 8 acts as 8.
module whole_word_occurrence_counter (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [wcc_pkg::PAT_W-1:0]     cfg_data,
    // text input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] text_byte
    input  logic                          s_tlast,   // end_of_text
    // count output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wcc_pkg::COUNT_W-1:0]   m_tdata    // [15:0] occurrence_count
);

    localparam int DEPTH = wcc_pkg::WINDOW_DEPTH;

    // configuration registers
    logic [wcc_pkg::PAT_W-1:0]   pattern_reg;
    logic [3:0]                  length_reg;
    logic [3:0]                  eff_len;

    // per-text state
    logic [wcc_pkg::SEEN_W-1:0]  seen_reg, seen_next, seen_inc;
    logic [wcc_pkg::COUNT_W-1:0] total_reg, total_next;
    logic [wcc_pkg::COUNT_W-1:0] total_a, total_b;

    // output register
    logic                        m_valid_reg, m_valid_next;
    logic [wcc_pkg::COUNT_W-1:0] m_data_reg, m_data_next;

    logic s_xfer;
    logic end_xfer;

    // cell row
    logic [7:0]           cell_in  [DEPTH];
    logic [7:0]           cell_out [DEPTH];
    wcc_pkg::cell_flags_t cell_flg [DEPTH];
    logic [DEPTH-1:0]     cmp_now_ok, cmp_next_ok;

    logic hit_prev;   // word ending on the previous byte, closed by this byte
    logic hit_last;   // word ending on the last byte of the text
    logic before_now, before_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= 4'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                wcc_pkg::REG_PATTERN_BYTES:  pattern_reg <= cfg_data;
                wcc_pkg::REG_PATTERN_LENGTH: length_reg  <= cfg_data[3:0];
                default:                     pattern_reg <= pattern_reg;
            endcase
        end
    end

    // clamp the written length into 1..MAX_WORD_LEN
    always_comb begin
        if (length_reg == 4'd0) begin
            eff_len = 4'd1;
        end else if (length_reg > 4'(wcc_pkg::MAX_WORD_LEN)) begin
            eff_len = 4'(wcc_pkg::MAX_WORD_LEN);
        end else begin
            eff_len = length_reg;
        end
    end

    // accept a new byte whenever the output register is free or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign end_xfer = s_xfer && s_tlast;

    // window cells: cell 0 holds the newest byte, each cell feeds the next
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign cell_in[g] = s_tdata;
            end else begin : g_tail
                assign cell_in[g] = cell_out[g-1];
            end

            wcc_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (s_xfer),
                .clear    (end_xfer),
                .pat_byte (wcc_pkg::pat_for_cell(pattern_reg, eff_len, 4'(g))),
                .byte_in  (cell_in[g]),
                .byte_out (cell_out[g]),
                .flags    (cell_flg[g])
            );

            // cells past the word length do not take part in the compare
            assign cmp_now_ok[g]  = cell_flg[g].eq_now  || (4'(g) >= eff_len);
            assign cmp_next_ok[g] = cell_flg[g].eq_next || (4'(g) >= eff_len);
        end
    endgenerate

    assign seen_inc = (seen_reg == wcc_pkg::SEEN_MAX) ? seen_reg
                                                      : seen_reg + 1'b1;

    // byte in front of the word: separator, or the word opens the text
    assign before_now  = (seen_reg > eff_len) ? cell_flg[eff_len[wcc_pkg::IDX_W-1:0]].low_now
                                              : 1'b1;
    assign before_next = (seen_inc > eff_len) ? cell_flg[eff_len[wcc_pkg::IDX_W-1:0]].low_next
                                              : 1'b1;

    // the incoming byte closes a word that ends in cell 0
    assign hit_prev = (seen_reg >= eff_len) && (s_tdata < wcc_pkg::WORD_LIMIT)
                   && (&cmp_now_ok) && before_now;
    // end of text closes a word that ends on the incoming byte
    assign hit_last = (seen_inc >= eff_len) && (&cmp_next_ok) && before_next;

    // two saturating increments, the second only on the last byte
    assign total_a = (hit_prev && total_reg != wcc_pkg::COUNT_MAX) ? total_reg + 1'b1
                                                                   : total_reg;
    assign total_b = (hit_last && total_a != wcc_pkg::COUNT_MAX) ? total_a + 1'b1
                                                                 : total_a;

    always_comb begin
        seen_next    = seen_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_xfer) begin
            if (s_tlast) begin
                // hand over the count and start a fresh text
                seen_next    = '0;
                total_next   = '0;
                m_valid_next = 1'b1;
                m_data_next  = total_b;
            end else begin
                seen_next  = seen_inc;
                total_next = total_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            seen_reg    <= seen_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // a text never carries state over into the next one
    assert property (@(posedge aclk) disable iff (!aresetn)
        end_xfer |=> (seen_reg == '0) && (total_reg == '0))
        else $error("text state not cleared after last byte");

    // input stalls only behind a pending count
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_valid_reg)
        else $error("input stalled with empty output register");

    // byte count advances by one on a mid-text byte until it saturates
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && !s_tlast && seen_reg != wcc_pkg::SEEN_MAX)
        |=> seen_reg == $past(seen_reg) + 1'b1)
        else $error("byte count did not advance");

    // clamped length stays within the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (eff_len >= 4'd1) && (eff_len <= 4'(wcc_pkg::MAX_WORD_LEN)))
        else $error("word length out of range");

endmodule
